### design/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
// No dependencies; every other design file imports this package.
`default_nettype none

package pli_pkg;

  // Command codes carried in the command field of an input beat
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Error codes returned with each result beat
  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_FEW_POINTS = 2'd1;
  localparam logic [1:0] ERR_ZERO_WIDTH = 2'd2;
  localparam logic [1:0] ERR_SATURATED  = 2'd3;

  // Divider operand widths
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;

  // Quotients above this bound saturate without further checks (2^40)
  localparam logic [DIVIDEND_W-1:0] QUO_LIMIT = 64'h0000_0100_0000_0000;

  // Saturation bounds for the 43-bit sum
  localparam logic signed [42:0] SUM_MAX = 43'sd2147483647;
  localparam logic signed [42:0] SUM_MIN = -43'sd2147483648;

  typedef struct packed {
    logic        command;
    logic [7:0]  point_index;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] query_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [7:0]  segment_index;
    logic [1:0]  error_code;
  } out_item_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } point_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LOAD,
    ST_MAG,
    ST_MUL,
    ST_DIVGO,
    ST_DIV
  } state_t;

endpackage

`default_nettype wire

### design/pli_mem.sv
// Breakpoint table: one write port, one read port, registered read data.
// Depends on pli_pkg for the entry type.
`default_nettype none

module pli_mem
  import pli_pkg::*;
#(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire point_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output point_t             rdata
);

  point_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/pli_div.sv
// Unsigned restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Depends on pli_pkg for the request and response structs.
`default_nettype none

module pli_div
  import pli_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CW = $clog2(DIVIDEND_W);

  logic                  running;
  logic                  done;
  logic [CW-1:0]         cnt;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W:0]    diff;

  // One shift-and-subtract step
  always_comb begin
    trial = {rem, quo[DIVIDEND_W-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !running) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DIVIDEND_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shifts out of quo while quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start && !running) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (running) begin
      rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[DIVIDEND_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

### design/piecewise_linear_interpolator.sv
// Piecewise linear interpolator: table search sequencer, arithmetic and result.
// Sequence: a write beat is taken in idle; a query with fewer than two points answers
// straight from idle; else the search steps through the table to segment p, then
// load, magnitude (a zero-width segment answers here), multiply, divider start, the
// divider steps and the result. One item in flight; busy drops as the result strobe
// rises. Reset: synchronous, count to 0, table kept; no stall.
`default_nettype none

module piecewise_linear_interpolator
  import pli_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t request,
  output logic          done,
  output out_item_t     result,
  input  wire logic     count_we,
  input  wire logic [8:0] count_data
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int SW   = AW + 2;
  localparam int CNTW = (NW > 9) ? NW : 9;
  localparam int WW   = ((AW > 8) ? AW : 8) + 1;

  state_t state, state_next;

  logic [8:0]        count;
  logic [NW-1:0]     n;
  logic [AW-1:0]     p;
  logic signed [31:0] v;
  logic [31:0]       x1, y1, y0;
  logic [32:0]       dx, dv, dy;
  logic [31:0]       mag_dx, mag_dv, mag_dy;
  logic              neg;
  logic [63:0]       prod;

  logic              accept;
  logic [CNTW-1:0]   cnt_ext, n_full;
  logic              few_points;
  logic              x_ge, last_seg, stop;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  point_t            mem_wdata, rd_data;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [42:0]       qv;
  logic signed [42:0] sum;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Point count clamped to the table depth
  always_comb begin
    cnt_ext    = CNTW'(count);
    n_full     = (cnt_ext > CNTW'(MAX_POINTS)) ? CNTW'(MAX_POINTS) : cnt_ext;
    few_points = n_full < CNTW'(2);
  end

  // Search compare on the entry read last cycle (entry p + 1)
  always_comb begin
    x_ge     = $signed(rd_data.x) >= v;
    last_seg = (SW'(p) + SW'(2)) >= SW'(n);
    stop     = x_ge || last_seg;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && request.command == CMD_QUERY && !few_points) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stop) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_MAG;
      ST_MAG: begin
        state_next = (dx == '0) ? ST_IDLE : ST_MUL;
      end
      ST_MUL:   state_next = ST_DIVGO;
      ST_DIVGO: state_next = ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory and divider controls
  always_comb begin
    mem_we          = 1'b0;
    mem_waddr       = AW'(request.point_index);
    mem_wdata.x     = request.point_x;
    mem_wdata.y     = request.point_y;
    mem_raddr       = p;
    div_req.start   = 1'b0;
    div_req.dividend = prod;
    div_req.divisor = mag_dx;
    case (state)
      ST_IDLE: begin
        mem_we    = accept && request.command == CMD_WRITE &&
                    (WW'(request.point_index) < WW'(MAX_POINTS));
        mem_raddr = AW'(1);
      end
      ST_SEARCH: begin
        // On stop fetch the lower entry, else run ahead to p + 2
        mem_raddr = stop ? p : AW'(SW'(p) + SW'(2));
      end
      ST_DIVGO: div_req.start = 1'b1;
      default: ;
    endcase
  end

  // Final sum on the quotient
  always_comb begin
    qv  = {2'b00, div_rsp.quotient[40:0]};
    sum = neg ? $signed({{11{y0[31]}}, y0} - qv) : $signed({{11{y0[31]}}, y0} + qv);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      if (count_we) begin
        count <= count_data;
      end
      done <= (state == ST_IDLE && accept && request.command == CMD_QUERY && few_points) ||
              (state == ST_MAG && dx == '0) ||
              (state == ST_DIV && div_rsp.done);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n <= NW'(n_full);
        p <= '0;
        v <= request.query_value;
        result.result_value  <= '0;
        result.segment_index <= '0;
        result.error_code    <= ERR_FEW_POINTS;
      end
      ST_SEARCH: begin
        if (stop) begin
          x1 <= rd_data.x;
          y1 <= rd_data.y;
        end else begin
          p <= p + AW'(1);
        end
      end
      ST_LOAD: begin
        y0 <= rd_data.y;
        dx <= {x1[31], x1} - {rd_data.x[31], rd_data.x};
        dv <= {v[31], v} - {rd_data.x[31], rd_data.x};
        dy <= {y1[31], y1} - {rd_data.y[31], rd_data.y};
      end
      ST_MAG: begin
        mag_dx <= dx[32] ? 32'(~dx + 33'd1) : dx[31:0];
        mag_dv <= dv[32] ? 32'(~dv + 33'd1) : dv[31:0];
        mag_dy <= dy[32] ? 32'(~dy + 33'd1) : dy[31:0];
        neg    <= dx[32] ^ dv[32] ^ dy[32];
        result.result_value  <= '0;
        result.segment_index <= 8'(p);
        result.error_code    <= ERR_ZERO_WIDTH;
      end
      ST_MUL: begin
        prod <= mag_dv * mag_dy;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient > QUO_LIMIT) begin
            result.result_value <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
            result.error_code   <= ERR_SATURATED;
          end else if (sum > SUM_MAX) begin
            result.result_value <= 32'h7FFF_FFFF;
            result.error_code   <= ERR_SATURATED;
          end else if (sum < SUM_MIN) begin
            result.result_value <= 32'h8000_0000;
            result.error_code   <= ERR_SATURATED;
          end else begin
            result.result_value <= sum[31:0];
            result.error_code   <= ERR_OK;
          end
        end
      end
      default: ;
    endcase
  end

  pli_mem #(
    .DEPTH (MAX_POINTS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  pli_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

`default_nettype wire

### design/pli_checker.sv
// Port-level checks for the piecewise linear interpolator, bound to the top.
// Depends on pli_pkg for the beat types and error codes.
`default_nettype none

module pli_checker
  import pli_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  request,
  input wire logic      done,
  input wire out_item_t result
);

  // A breakpoint write completes at once and makes no result
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == CMD_WRITE |=> !done && !busy)
    else $error("write beat left the block busy or made a result");

  // A query either starts work or answers next cycle with too few points
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.command == CMD_QUERY |=>
      busy || (done && result.error_code == ERR_FEW_POINTS))
    else $error("query neither started nor answered");

  // The result strobe comes as the block returns to idle
  assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Saturated results sit on a bound
  assert property (@(posedge clk) disable iff (rst)
    done && result.error_code == ERR_SATURATED |->
      result.result_value == 32'h7FFF_FFFF || result.result_value == 32'h8000_0000)
    else $error("saturated result not clamped");

  // Too-few-points and zero-width results carry zero
  assert property (@(posedge clk) disable iff (rst)
    done && (result.error_code == ERR_FEW_POINTS || result.error_code == ERR_ZERO_WIDTH) |->
      result.result_value == 32'h0)
    else $error("error result not zero");

endmodule

bind piecewise_linear_interpolator pli_checker u_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

`default_nettype wire
